// ===== hdl/modular_inverse_euclid_defines.svh =====
// Assertion macros for the modular inverse block.
// Used by the controller and datapath; relies on clk and rst_n in scope.
`ifndef MODULAR_INVERSE_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EUCLID_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define MIE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset
`define MIE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MIE_ASSERT_IMP(label, ante, cons, msg)
`define MIE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/mie_pkg.sv =====
// Shared types and constants for the modular inverse block.
// No dependencies.
package mie_pkg;

    // default operand and modulus width
    localparam int WIDTH_DEF = 64;

    // modulus value after reset
    localparam int MODULUS_RESET = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // take operand, start a new transaction
        logic div_init;  // set up the divider for one round
        logic div_step;  // one quotient bit
        logic update;    // close the round: shift remainders and coefficients
        logic finish;    // apply sign correction, register the result
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic rcur_zero; // current remainder is zero: recurrence ends
    } status_t;

endpackage

// ===== hdl/mie_datapath.sv =====
// Datapath: remainder and coefficient registers, bit-serial divider and
// multiply-accumulate, final sign correction. Depends on mie_pkg.
`include "modular_inverse_euclid_defines.svh"
module mie_datapath #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             modulus_wr_en,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] operand,
    input  mie_pkg::cmd_t    cmd,
    output mie_pkg::status_t status,
    output logic [WIDTH-1:0] inverse_value
);

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] rprev_reg, rprev_next;
    logic [WIDTH-1:0] rcur_reg,  rcur_next;
    logic [WIDTH-1:0] mprev_reg, mprev_next;
    logic [WIDTH-1:0] mcur_reg,  mcur_next;
    logic [WIDTH-1:0] part_reg,  part_next;   // partial remainder
    logic [WIDTH-1:0] dq_reg,    dq_next;     // dividend in, quotient out
    logic [WIDTH-1:0] acc_reg,   acc_next;    // quotient * mcur, mod 2^WIDTH
    logic             odd_reg,   odd_next;    // round count parity
    logic             any_reg,   any_next;    // at least one round run
    logic [WIDTH-1:0] result_reg, result_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             qbit;
    logic             negative;

    // modulus register and round parity flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WIDTH'(mie_pkg::MODULUS_RESET);
            odd_reg     <= 1'b0;
            any_reg     <= 1'b0;
        end
        else
        begin
            if (modulus_wr_en)
            begin
                modulus_reg <= modulus;
            end
            odd_reg <= odd_next;
            any_reg <= any_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rprev_reg  <= rprev_next;
        rcur_reg   <= rcur_next;
        mprev_reg  <= mprev_next;
        mcur_reg   <= mcur_next;
        part_reg   <= part_next;
        dq_reg     <= dq_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    // one restoring division step; remainder stays below the divisor
    always_comb
    begin
        trial = {part_reg, dq_reg[WIDTH-1]};
        diff  = trial - {1'b0, rcur_reg};
        qbit  = (trial >= {1'b0, rcur_reg});
    end

    // final coefficient is negative after an even, nonzero round count
    assign negative = (mprev_reg != '0) && any_reg && !odd_reg;

    // next-state logic
    always_comb
    begin
        rprev_next  = rprev_reg;
        rcur_next   = rcur_reg;
        mprev_next  = mprev_reg;
        mcur_next   = mcur_reg;
        part_next   = part_reg;
        dq_next     = dq_reg;
        acc_next    = acc_reg;
        odd_next    = odd_reg;
        any_next    = any_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            rprev_next = modulus_reg;
            rcur_next  = operand;
            mprev_next = '0;
            mcur_next  = WIDTH'(1);
            odd_next   = 1'b0;
            any_next   = 1'b0;
        end

        if (cmd.div_init)
        begin
            part_next = '0;
            dq_next   = rprev_reg;
            acc_next  = '0;
        end

        // quotient bits arrive MSB first: acc = 2*acc + q*mcur
        if (cmd.div_step)
        begin
            part_next = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            dq_next   = {dq_reg[WIDTH-2:0], qbit};
            acc_next  = (acc_reg << 1) + (qbit ? mcur_reg : '0);
        end

        if (cmd.update)
        begin
            rprev_next = rcur_reg;
            rcur_next  = part_reg;
            mprev_next = mcur_reg;
            mcur_next  = mprev_reg + acc_reg;
            odd_next   = !odd_reg;
            any_next   = 1'b1;
        end

        if (cmd.finish)
        begin
            result_next = negative ? (modulus_reg - mprev_reg) : mprev_reg;
        end
    end

    assign status.rcur_zero = (rcur_reg == '0);
    assign inverse_value    = result_reg;

    // checks
    `MIE_ASSERT_IMP(a_div_nonzero, cmd.div_step || cmd.div_init, rcur_reg != '0,
        "divider run with zero divisor")
    `MIE_ASSERT_NXT(a_round_counted, cmd.update, any_reg && (odd_reg != $past(odd_reg)),
        "round parity not advanced")

endmodule

// ===== hdl/mie_ctrl.sv =====
// Controller: sequences rounds of the Euclid recurrence and the divider
// steps inside each round. Depends on mie_pkg.
`include "modular_inverse_euclid_defines.svh"
module mie_ctrl #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output mie_pkg::cmd_t    cmd,
    input  mie_pkg::status_t status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             done_reg,  done_next;

    // state, step counter and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.rcur_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // checks
    `MIE_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    `MIE_ASSERT_IMP(a_done_idle, done_reg, !busy, "result strobe while busy")
    `MIE_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction did not start")

endmodule

// ===== hdl/modular_inverse_euclid.sv =====
// Top level of the modular inverse block: controller plus datapath.
// Depends on mie_pkg, mie_ctrl and mie_datapath.
//
//   channel   handshake            payload
//   config    modulus_wr_en        modulus
//   input     start, busy          operand
//   result    done                 inverse_value
//
// A transaction is taken when start is high and busy is low.
// Each Euclid round is a check step, the divider steps at one quotient bit
// per cycle, and an update step; busy stays high through the rounds, a final
// check and the finish step, and done strobes in the first cycle with busy
// low. An operand of zero goes from the check step straight to finish.
// done strobes for one cycle with inverse_value and cannot be held off; the
// result holds until the next transaction completes. Reset sets the modulus
// to 2 and idles.
module modular_inverse_euclid #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             modulus_wr_en,
    input  logic [WIDTH-1:0] modulus,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] operand,
    output logic             done,
    output logic [WIDTH-1:0] inverse_value
);

    mie_pkg::cmd_t    cmd;
    mie_pkg::status_t status;

    // sequencer
    mie_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // arithmetic
    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_wr_en (modulus_wr_en),
        .modulus       (modulus),
        .operand       (operand),
        .cmd           (cmd),
        .status        (status),
        .inverse_value (inverse_value)
    );

endmodule
